// ----- src/mvf_pkg.sv -----
// Shared constants, types and a helper function for the moving average filter.
package mvf_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int WINDOW_MIN   = 2;
   localparam int SAMPLE_WIDTH = 16;
   localparam int WINDOW_WIDTH = 7;
   localparam int PTR_WIDTH    = $clog2(WINDOW_MAX);
   localparam int COUNT_WIDTH  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
   localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [PTR_WIDTH-1:0]    ptr_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [SUM_WIDTH-1:0]    sum_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE
   } state_type;

   // Ring write port, driven by the control logic.
   typedef struct packed {
      logic       en;
      ptr_type    addr;
      sample_type data;
   } ring_write_type;

   // Limits a written window length to the supported range.
   function automatic count_type clamp_window(input logic [WINDOW_WIDTH-1:0] value);
      logic [WINDOW_WIDTH:0] wide;
      begin
         wide = {1'b0, value};
         if (wide < (WINDOW_WIDTH + 1)'(WINDOW_MIN)) begin
            return count_type'(WINDOW_MIN);
         end else if (wide > (WINDOW_WIDTH + 1)'(WINDOW_MAX)) begin
            return count_type'(WINDOW_MAX);
         end else begin
            return count_type'(wide);
         end
      end
   endfunction

endpackage

// ----- src/mvf_if.sv -----
// Handshake interfaces for the sample and result channels.
interface mvf_req_if
   import mvf_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface mvf_rsp_if
   import mvf_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type mean;
   logic       window_full;

   modport source (output valid, output mean, output window_full, input ready);
   modport sink (input valid, input mean, input window_full, output ready);
endinterface

// ----- src/mvf_ring.sv -----
// Sample ring memory with per-entry valid bits so that unwritten slots read as zero.
module mvf_ring
   import mvf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           clear,
   input  ptr_type        rd_addr,
   output sample_type     rd_data,
   input  ring_write_type wr
);

   sample_type              mem [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   valid_ff;
   logic [WINDOW_MAX-1:0]   valid_in;
   sample_type              rd_data_ff;
   logic                    rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- src/mvf_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module mvf_divider
   import mvf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  sum_type   dividend,
   input  count_type divisor,
   output logic      done,
   output sum_type   quotient
);

   sum_type                 shift_ff, shift_in;
   count_type               rem_ff, rem_in;
   count_type               divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [COUNT_WIDTH:0]    trial;
   logic [COUNT_WIDTH:0]    diff;
   logic                    fits;

   always_comb begin
      // The partial remainder takes the next dividend bit from the top of the shifter.
      trial = {rem_ff, shift_ff[SUM_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};

      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;

      if (start) begin
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = STEP_WIDTH'(SUM_WIDTH - 1);
         busy_in    = 1'b1;
         done_in    = 1'b0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[SUM_WIDTH-2:0], fits};
         rem_in   = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// ----- src/moving_average_filter_top.sv -----
// Top level of the moving average filter: control, running sum and result register.
//
//   Channel   Direction   Beat contents
//   req_bus   in          sample[15:0]
//   rsp_bus   out         mean[15:0], window_full
//   csr       in          csr_wdata[6:0] = window_size, written when csr_we is high
//
// Each sample beat goes through one ring read, one sum update and the bit-serial
// divider before its result is loaded. The next sample is taken at the earliest
// in the cycle after that load.
// The block takes one sample at a time; a result waiting in the output register
// does not hold off the next sample, only the loading of its result.
// Reset is synchronous; it empties the ring, clears the sum, pointer and fill
// count and sets the window length to two. A window write does the same clearing.
module moving_average_filter_top
   import mvf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   mvf_req_if.sink                 req_bus,
   mvf_rsp_if.source               rsp_bus,
   input  logic                    csr_we,
   input  logic [WINDOW_WIDTH-1:0] csr_wdata
);

   state_type      state_ff, state_in;
   ptr_type        wp_ff, wp_in;
   sum_type        sum_ff, sum_in;
   count_type      fill_ff, fill_in;
   count_type      ws_ff, ws_in;
   sample_type     sample_ff;
   logic           full_pend_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   sample_type     mean_ff;
   logic           full_ff;

   logic           req_ready;
   logic           div_start;
   logic           rsp_load;
   logic           div_done;
   sum_type        quotient;
   sample_type     old_sample;
   ring_write_type ring_wr;
   ptr_type        slot;
   count_type      slot_next;

   // A pointer at or past the window end wraps to slot zero before use.
   assign slot      = (count_type'(wp_ff) >= ws_ff) ? '0 : wp_ff;
   assign slot_next = count_type'(slot) + 1'b1;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done && (!rsp_valid_ff || rsp_bus.ready)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wp_in   = wp_ff;
      sum_in  = sum_ff;
      fill_in = fill_ff;
      ws_in   = ws_ff;
      if (csr_we) begin
         ws_in   = clamp_window(csr_wdata);
         wp_in   = '0;
         sum_in  = '0;
         fill_in = '0;
      end else if (div_start) begin
         sum_in  = sum_ff - sum_type'(old_sample) + sum_type'(sample_ff);
         wp_in   = (slot_next >= ws_ff) ? '0 : slot_next[PTR_WIDTH-1:0];
         if (fill_ff < ws_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         ws_ff        <= count_type'(WINDOW_MIN);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         ws_ff        <= ws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         sample_ff <= req_bus.sample;
      end
      if (div_start) begin
         full_pend_ff <= (fill_in >= ws_ff);
      end
      if (rsp_load) begin
         mean_ff <= quotient[SAMPLE_WIDTH-1:0];
         full_ff <= full_pend_ff;
      end
   end

   assign ring_wr.en   = div_start;
   assign ring_wr.addr = slot;
   assign ring_wr.data = sample_ff;

   mvf_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_we),
      .rd_addr (slot),
      .rd_data (old_sample),
      .wr      (ring_wr)
   );

   mvf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (ws_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.mean        = mean_ff;
   assign rsp_bus.window_full = full_ff;

endmodule

// ----- src/mvf_checker.sv -----
// Port-level assertions for the moving average filter and the bind that attaches them.
module mvf_checker
   import mvf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_mean,
   input logic       rsp_window_full
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_mean) && $stable(rsp_window_full)))
      else $error("result payload changed while stalled");

   // The filter works on one sample at a time, so it is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while the previous one is in progress");

   // Results come from the bit-serial divider, so no new result can appear right after a sample.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after its sample");

endmodule

bind moving_average_filter_top mvf_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_mean        (rsp_bus.mean),
   .rsp_window_full (rsp_bus.window_full)
);
